@@ design/tnrx_pkg.sv @@
// ----------------------------------------------------------------------------
// tnrx_pkg
// Shared types and codes for the Telnet receive option negotiator.
// ----------------------------------------------------------------------------
package tnrx_pkg;

	localparam logic [7:0] TN_SE   = 8'd240;
	localparam logic [7:0] TN_NOP  = 8'd241;
	localparam logic [7:0] TN_BRK  = 8'd243;
	localparam logic [7:0] TN_GA   = 8'd249;
	localparam logic [7:0] TN_SB   = 8'd250;
	localparam logic [7:0] TN_WILL = 8'd251;
	localparam logic [7:0] TN_WONT = 8'd252;
	localparam logic [7:0] TN_DO   = 8'd253;
	localparam logic [7:0] TN_DONT = 8'd254;
	localparam logic [7:0] TN_IAC  = 8'd255;

	localparam logic [7:0] OPT_BIN   = 8'd0;
	localparam logic [7:0] OPT_ECHO  = 8'd1;
	localparam logic [7:0] OPT_SGA   = 8'd3;
	localparam logic [7:0] OPT_TTYPE = 8'd24;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_EOT = 8'h04;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_DEL = 8'h7F;

	localparam logic [1:0] CFG_CONSOLE_MODE = 2'd0;
	localparam logic [1:0] CFG_DISABLE_ECHO = 2'd1;
	localparam logic [1:0] CFG_TTYPE_SET    = 2'd2;

	localparam logic [1:0] KIND_UART    = 2'd0;
	localparam logic [1:0] KIND_CONSOLE = 2'd1;
	localparam logic [1:0] KIND_BREAK   = 2'd2;
	localparam logic [1:0] KIND_REPLY   = 2'd3;

	localparam int QDEPTH = 2;
	localparam int QAW    = 1;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		logic       tt;
		res_t [2:0] res;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ design/tnrx_front.sv @@
// ----------------------------------------------------------------------------
// tnrx_front
// Parses received bytes, tracks command and line-end state, builds result jobs.
// ----------------------------------------------------------------------------
module tnrx_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic                cfg_data,
	input  logic                rx_valid,
	output logic                rx_ready,
	input  logic [7:0]          rx_byte,
	input  tnrx_pkg::q_stat_t   q_stat,
	output logic                push,
	output tnrx_pkg::job_t      job
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_IAC  = 3'b010,
		PH_VERB = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		VB_WILL = 2'd0,
		VB_WONT = 2'd1,
		VB_DO   = 2'd2,
		VB_DONT = 2'd3
	} verb_t;

	phase_t phase_q, phase_d;
	logic   subneg_q, subneg_d;
	verb_t  verb_q, verb_d;
	logic   verb_ok_q, verb_ok_d;
	logic   pend_cr_q, pend_cr_d;
	logic   pend_lf_q, pend_lf_d;
	logic   console_q, echo_q, ttset_q;

	logic       acc;
	logic       run_data;
	logic [7:0] d;
	logic [7:0] pend_byte;
	logic [7:0] rv;

	function automatic tnrx_pkg::res_t route(input logic console, input logic [7:0] x);
		tnrx_pkg::res_t r;
		r.data = x;
		if (console)
			r.kind = tnrx_pkg::KIND_CONSOLE;
		else if (x == tnrx_pkg::CH_EOT)
			r.kind = tnrx_pkg::KIND_BREAK;
		else
			r.kind = tnrx_pkg::KIND_UART;
		return r;
	endfunction

	assign rx_ready = !q_stat.full;
	assign acc      = rx_valid && rx_ready;
	assign d        = (rx_byte == tnrx_pkg::CH_DEL) ? tnrx_pkg::CH_BS : rx_byte;
	assign pend_byte = pend_cr_q ? tnrx_pkg::CH_CR : tnrx_pkg::CH_LF;

	always_comb begin
		rv = tnrx_pkg::TN_WONT;
		unique case (verb_q)
			VB_WILL: begin
				if (rx_byte == tnrx_pkg::OPT_BIN || rx_byte == tnrx_pkg::OPT_SGA)
					rv = tnrx_pkg::TN_DO;
				else if (rx_byte == tnrx_pkg::OPT_ECHO)
					rv = echo_q ? tnrx_pkg::TN_DONT : tnrx_pkg::TN_DO;
				else
					rv = tnrx_pkg::TN_DONT;
			end
			VB_WONT: rv = (rx_byte == tnrx_pkg::OPT_BIN) ? tnrx_pkg::TN_DO : tnrx_pkg::TN_DONT;
			VB_DO: begin
				if (rx_byte == tnrx_pkg::OPT_BIN || rx_byte == tnrx_pkg::OPT_SGA)
					rv = tnrx_pkg::TN_WILL;
				else if (rx_byte == tnrx_pkg::OPT_TTYPE)
					rv = ttset_q ? tnrx_pkg::TN_WILL : tnrx_pkg::TN_WONT;
				else if (rx_byte == tnrx_pkg::OPT_ECHO)
					rv = echo_q ? tnrx_pkg::TN_WILL : tnrx_pkg::TN_WONT;
				else
					rv = tnrx_pkg::TN_WONT;
			end
			VB_DONT: rv = (rx_byte == tnrx_pkg::OPT_BIN) ? tnrx_pkg::TN_WILL : tnrx_pkg::TN_WONT;
			default: rv = tnrx_pkg::TN_WONT;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		subneg_d  = subneg_q;
		verb_d    = verb_q;
		verb_ok_d = verb_ok_q;
		pend_cr_d = pend_cr_q;
		pend_lf_d = pend_lf_q;
		run_data  = 1'b0;
		job       = '0;
		if (subneg_q) begin
			if (phase_q == PH_IDLE && rx_byte == tnrx_pkg::TN_IAC) begin
				phase_d = PH_IAC;
			end else if (phase_q == PH_IAC && rx_byte == tnrx_pkg::TN_SE) begin
				subneg_d = 1'b0;
				phase_d  = PH_IDLE;
			end else begin
				phase_d = PH_IDLE;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					if (rx_byte == tnrx_pkg::TN_IAC)
						phase_d = PH_IAC;
					else
						run_data = 1'b1;
				end
				PH_IAC: begin
					phase_d = PH_IDLE;
					if (rx_byte == tnrx_pkg::TN_IAC) begin
						run_data = 1'b1;
					end else if (rx_byte == tnrx_pkg::TN_NOP || rx_byte == tnrx_pkg::TN_BRK
							|| rx_byte == tnrx_pkg::TN_GA) begin
						phase_d = PH_IDLE;
					end else if (rx_byte == tnrx_pkg::TN_SB) begin
						subneg_d = 1'b1;
					end else begin
						phase_d   = PH_VERB;
						verb_ok_d = 1'b1;
						unique case (rx_byte)
							tnrx_pkg::TN_WILL: verb_d = VB_WILL;
							tnrx_pkg::TN_WONT: verb_d = VB_WONT;
							tnrx_pkg::TN_DO:   verb_d = VB_DO;
							tnrx_pkg::TN_DONT: verb_d = VB_DONT;
							default:           verb_ok_d = 1'b0;
						endcase
					end
				end
				PH_VERB: begin
					phase_d = PH_IDLE;
					if (verb_ok_q) begin
						job.cnt    = 2'd3;
						job.res[0] = '{kind: tnrx_pkg::KIND_REPLY, data: tnrx_pkg::TN_IAC};
						job.res[1] = '{kind: tnrx_pkg::KIND_REPLY, data: rv};
						job.res[2] = '{kind: tnrx_pkg::KIND_REPLY, data: rx_byte};
						job.tt     = (rv == tnrx_pkg::TN_WILL) && (rx_byte == tnrx_pkg::OPT_TTYPE);
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end

		if (run_data) begin
			if (!pend_cr_q && !pend_lf_q && (d == tnrx_pkg::CH_LF || d == tnrx_pkg::CH_CR)) begin
				pend_cr_d = (d == tnrx_pkg::CH_CR);
				pend_lf_d = (d == tnrx_pkg::CH_LF);
			end else if ((pend_lf_q && d == tnrx_pkg::CH_CR)
					|| (pend_cr_q && d == tnrx_pkg::CH_NUL)) begin
				pend_cr_d  = 1'b0;
				pend_lf_d  = 1'b0;
				job.cnt    = 2'd2;
				job.res[0] = route(console_q, tnrx_pkg::CH_CR);
				job.res[1] = route(console_q, tnrx_pkg::CH_LF);
			end else if (pend_cr_q || pend_lf_q) begin
				pend_cr_d  = 1'b0;
				pend_lf_d  = 1'b0;
				job.cnt    = 2'd2;
				job.res[0] = route(console_q, pend_byte);
				job.res[1] = route(console_q, d);
			end else begin
				job.cnt    = 2'd1;
				job.res[0] = route(console_q, d);
			end
		end
	end

	assign push = acc && (job.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			subneg_q  <= 1'b0;
			verb_q    <= VB_WILL;
			verb_ok_q <= 1'b0;
			pend_cr_q <= 1'b0;
			pend_lf_q <= 1'b0;
		end else if (acc) begin
			phase_q   <= phase_d;
			subneg_q  <= subneg_d;
			verb_q    <= verb_d;
			verb_ok_q <= verb_ok_d;
			pend_cr_q <= pend_cr_d;
			pend_lf_q <= pend_lf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			console_q <= 1'b0;
			echo_q    <= 1'b0;
			ttset_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tnrx_pkg::CFG_CONSOLE_MODE: console_q <= cfg_data;
				tnrx_pkg::CFG_DISABLE_ECHO: echo_q    <= cfg_data;
				tnrx_pkg::CFG_TTYPE_SET:    ttset_q   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ design/tnrx_queue.sv @@
// ----------------------------------------------------------------------------
// tnrx_queue
// Short job queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module tnrx_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tnrx_pkg::job_t    wr_job,
	input  logic              pop,
	output tnrx_pkg::job_t    head,
	output tnrx_pkg::q_stat_t stat
);

	tnrx_pkg::job_t               mem_q [tnrx_pkg::QDEPTH];
	logic [tnrx_pkg::QAW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [tnrx_pkg::QAW:0]       cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == (tnrx_pkg::QAW+1)'(tnrx_pkg::QDEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + tnrx_pkg::QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + tnrx_pkg::QAW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (tnrx_pkg::QAW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (tnrx_pkg::QAW+1)'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full && !pop)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty)) else $error("queue underflow");

endmodule

@@ design/tnrx_back.sv @@
// ----------------------------------------------------------------------------
// tnrx_back
// Steps through each queued job and presents one result per transfer.
// ----------------------------------------------------------------------------
module tnrx_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tnrx_pkg::job_t    head,
	input  tnrx_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [1:0]        result_kind,
	output logic [7:0]        result_byte,
	output logic              last,
	output logic              send_terminal_type
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       tt_q;

	logic           load;
	logic           last_w;
	tnrx_pkg::res_t cur;

	assign load   = !q_stat.empty && (!valid_q || res_ready);
	assign last_w = (idx_q == head.cnt - 2'd1);
	assign cur    = head.res[idx_q];
	assign pop    = load && last_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= last_w ? 2'd0 : idx_q + 2'd1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= cur.kind;
			byte_q <= cur.data;
			last_q <= last_w;
			tt_q   <= last_w && head.tt;
		end
	end

	assign res_valid          = valid_q;
	assign result_kind        = kind_q;
	assign result_byte        = byte_q;
	assign last               = last_q;
	assign send_terminal_type = tt_q;

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.empty |-> idx_q == 2'd0) else $error("index left mid-job");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> idx_q < head.cnt) else $error("index beyond job");
	a_tt_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && tt_q) |-> (last_q && kind_q == tnrx_pkg::KIND_REPLY))
		else $error("terminal type flag off a reply end");

endmodule

@@ design/telnet_rx_option_negotiator_unit.sv @@
// ----------------------------------------------------------------------------
// telnet_rx_option_negotiator_unit
// Telnet receive path: strips IAC commands, answers option negotiation,
// normalizes line ends and routes data to the UART (EOT as a break) or the console.
// ----------------------------------------------------------------------------
//  channel  signals                                    dir  transfer on
//  rx       rx_valid rx_ready rx_byte                  in   rx_valid & rx_ready
//  res      res_valid res_ready result_kind            out  res_valid & res_ready
//           result_byte last send_terminal_type
//  cfg      cfg_we cfg_index cfg_data                  in   cfg_we
//
//  A byte is parsed in the cycle it is taken; its one to three results leave
//  the output register one per cycle while res_ready stays high.
//  The two-entry job queue lets the parser take bytes while results wait.
//  Bytes that cause no result push no job and touch only state.
//  Reset returns the parser to idle, empties the queue and clears the configuration to zero.
// ----------------------------------------------------------------------------
module telnet_rx_option_negotiator_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic       cfg_data,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [1:0] result_kind,
	output logic [7:0] result_byte,
	output logic       last,
	output logic       send_terminal_type
);

	tnrx_pkg::job_t    wr_job;
	tnrx_pkg::job_t    head;
	tnrx_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;

	tnrx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.q_stat    (q_stat),
		.push      (push),
		.job       (wr_job)
	);

	tnrx_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.head   (head),
		.stat   (q_stat)
	);

	tnrx_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.head               (head),
		.q_stat             (q_stat),
		.pop                (pop),
		.res_valid          (res_valid),
		.res_ready          (res_ready),
		.result_kind        (result_kind),
		.result_byte        (result_byte),
		.last               (last),
		.send_terminal_type (send_terminal_type)
	);

endmodule
